// File: design/udiv_pkg.sv
// Shared constants and types for the unsigned divider core.
package udiv_pkg;

    // Operand width actually divided; bits above it are ignored.
    localparam int WIDTH = 64;
    // Width of each field on the stream ports.
    localparam int FIELD_W = 64;
    // Step counter width: counts 0 .. WIDTH-1.
    localparam int CNT_W = $clog2(WIDTH);

    // Controls broadcast to every bit cell of the row.
    typedef struct packed {
        logic load;
        logic step;
    } udiv_ctl_t;

endpackage

// File: design/unsigned_divider_core.sv
// Unsigned divider core: stream front end, step sequencer and result register.
//
//  channel  | dir | tdata (low bit up)               | tuser
//  ---------+-----+----------------------------------+----------------
//  s_axis   | in  | numerator[63:0], denominator[63:0] | -
//  m_axis   | out | quot[63:0], remain[63:0]          | div_zero_error
//
// A request first loads the cell row, then runs WIDTH steps of the row (one
// quotient bit each) and finally moves the result out to the output register.
// A zero divisor skips the steps and goes from the load straight to the move out.
// Only one request is in flight; a new one is taken while the last result waits.
// A stalled result holds the finished request in the row until the output frees.
// Reset clears the sequencer and the output valid; the row needs no reset.
module unsigned_divider_core
    import udiv_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [2*FIELD_W-1:0] s_axis_tdata,  // numerator, denominator
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [2*FIELD_W-1:0] m_axis_tdata,  // quot, remain
    output logic                 m_axis_tuser   // div_zero_error
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic                 zero_reg;
    logic                 zero_next;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [2*FIELD_W-1:0] m_data_reg;
    logic                 m_user_reg;

    logic                 accept;
    logic                 out_free;
    logic                 emit;
    logic                 den_zero;
    logic [WIDTH-1:0]     num_w;
    logic [WIDTH-1:0]     den_w;
    logic [WIDTH-1:0]     quot_w;
    logic [WIDTH-1:0]     remain_w;
    udiv_ctl_t            ctl;

    assign num_w    = s_axis_tdata[WIDTH-1:0];
    assign den_w    = s_axis_tdata[FIELD_W +: WIDTH];
    assign den_zero = (den_w == '0);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign out_free      = ~m_valid_reg | m_axis_tready;
    assign emit          = (state_reg == ST_FIN) & out_free;

    assign ctl.load = accept;
    assign ctl.step = (state_reg == ST_RUN);

    udiv_row u_row (
        .clk         (clk),
        .ctl         (ctl),
        .numerator   (num_w),
        .denominator (den_w),
        .quot        (quot_w),
        .remain      (remain_w)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        zero_next  = zero_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    zero_next  = den_zero;
                    cnt_next   = '0;
                    state_next = den_zero ? ST_FIN : ST_RUN;
                end
            end
            ST_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (emit)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            zero_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            zero_reg    <= zero_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            // Drop quotient and remainder on a zero divisor
            m_data_reg[FIELD_W-1:0]       <= zero_reg ? '0 : FIELD_W'(quot_w);
            m_data_reg[2*FIELD_W-1:FIELD_W] <= zero_reg ? '0 : FIELD_W'(remain_w);
            m_user_reg                    <= zero_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_RUN || state_reg == ST_FIN))
        else $error("accepted request did not start");

    a_zero_skips: assert property (@(posedge clk) disable iff (!rst_n)
        accept && den_zero |=> state_reg == ST_FIN && zero_reg)
        else $error("zero divisor did not skip the steps");

    a_run_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN && cnt_reg != CNT_LAST |=> state_reg == ST_RUN)
        else $error("step sequence ended early");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("divide-by-zero result carries data");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("pending result overwritten");

endmodule

// File: design/udiv_cell.sv
// One bit slice of the divider row: remainder, dividend/quotient and divisor bits.
module udiv_cell
    import udiv_pkg::*;
(
    input  logic      clk,
    input  udiv_ctl_t ctl,
    input  logic      n_bit,
    input  logic      d_bit,
    input  logic      s_in,
    input  logic      a_in,
    input  logic      b_in,
    input  logic      take,
    output logic      r_out,
    output logic      a_out,
    output logic      b_out
);

    logic r_reg;
    logic a_reg;
    logic d_reg;
    logic diff;

    // Ripple subtract of the divisor bit from the shifted remainder bit
    assign diff  = s_in ^ d_reg ^ b_in;
    assign b_out = (~s_in & d_reg) | (~(s_in ^ d_reg) & b_in);

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            r_reg <= 1'b0;
            a_reg <= n_bit;
            d_reg <= d_bit;
        end
        else if (ctl.step)
        begin
            r_reg <= take ? diff : s_in;
            a_reg <= a_in;
        end
    end

    assign r_out = r_reg;
    assign a_out = a_reg;

endmodule

// File: design/udiv_row.sv
// Row of bit cells that performs one restoring division step per cycle.
module udiv_row
    import udiv_pkg::*;
(
    input  logic             clk,
    input  udiv_ctl_t        ctl,
    input  logic [WIDTH-1:0] numerator,
    input  logic [WIDTH-1:0] denominator,
    output logic [WIDTH-1:0] quot,
    output logic [WIDTH-1:0] remain
);

    logic [WIDTH-1:0] r_w;
    logic [WIDTH-1:0] a_w;
    logic [WIDTH:0]   b_w;
    logic             take;

    assign b_w[0] = 1'b0;
    // Subtract when the bit shifted out was set or no borrow came out the top
    assign take = r_w[WIDTH-1] | ~b_w[WIDTH];

    for (genvar i = 0; i < WIDTH; i++)
    begin : g_cell
        logic s_in;
        logic a_in;

        if (i == 0)
        begin : g_low
            // Next dividend bit enters the remainder; new quotient bit enters the shifter
            assign s_in = a_w[WIDTH-1];
            assign a_in = take;
        end
        else
        begin : g_mid
            assign s_in = r_w[i-1];
            assign a_in = a_w[i-1];
        end

        udiv_cell u_cell (
            .clk   (clk),
            .ctl   (ctl),
            .n_bit (numerator[i]),
            .d_bit (denominator[i]),
            .s_in  (s_in),
            .a_in  (a_in),
            .b_in  (b_w[i]),
            .take  (take),
            .r_out (r_w[i]),
            .a_out (a_w[i]),
            .b_out (b_w[i+1])
        );
    end

    assign quot   = a_w;
    assign remain = r_w;

endmodule

// File: test/tb.sv
// Self-checking stream testbench for the unsigned divider core.
module tb;

    import udiv_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_COUNT = 750;
    localparam int DRAIN_CYCLES = 2 * WIDTH + 8;
    localparam int MAX_PRINTS = 50;

    typedef struct packed {
        logic [FIELD_W-1:0] denominator;
        logic [FIELD_W-1:0] numerator;
    } div_request_t;

    typedef struct packed {
        logic [FIELD_W-1:0] quot;
        logic [FIELD_W-1:0] remain;
        logic               div_zero_error;
    } div_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [2*FIELD_W-1:0] s_axis_tdata = '0;  // numerator, denominator
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [2*FIELD_W-1:0] m_axis_tdata;       // quot, remain
    logic                 m_axis_tuser;       // div_zero_error

    div_request_t pending_requests[$];
    div_result_t  expected_results[$];

    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned idle_cycles = 0;
    int unsigned send_wait = 0;
    int unsigned recv_wait = 0;
    int unsigned hold_left = 0;
    int unsigned send_draw;
    int unsigned recv_draw;
    bit          send_burst = 1'b0;
    bit          recv_burst = 1'b0;

    unsigned_divider_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Restoring division with a partial remainder one bit wider than the operands.
    function automatic div_result_t divide_operands(div_request_t req);
        logic [WIDTH-1:0] dividend;
        logic [WIDTH-1:0] divisor;
        logic [WIDTH-1:0] quotient;
        logic [WIDTH:0]   partial;
        div_result_t      res;
        int               i;
        dividend = req.numerator[WIDTH-1:0];
        divisor = req.denominator[WIDTH-1:0];
        res = '0;
        if (divisor == '0)
        begin
            res.div_zero_error = 1'b1;
        end
        else
        begin
            partial = '0;
            quotient = '0;
            for (i = WIDTH - 1; i >= 0; i--)
            begin
                partial = {partial[WIDTH-1:0], dividend[i]};
                if (partial >= {1'b0, divisor})
                begin
                    partial = partial - {1'b0, divisor};
                    quotient[i] = 1'b1;
                end
            end
            res.quot[WIDTH-1:0] = quotient;
            res.remain[WIDTH-1:0] = partial[WIDTH-1:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatches < MAX_PRINTS)
            $display("tb: mismatch at result %0d: %s", results_seen, msg);
        mismatches++;
    endtask

    function automatic logic [FIELD_W-1:0] random_operand();
        logic [FIELD_W-1:0] v;
        v = {$urandom(), $urandom()};
        return v >> $urandom_range(0, FIELD_W - 1);
    endfunction

    task automatic queue_division(logic [FIELD_W-1:0] num, logic [FIELD_W-1:0] den);
        div_request_t req;
        req.numerator = num;
        req.denominator = den;
        pending_requests.push_back(req);
    endtask

    // Request driver: present queued requests, random gap after each one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            send_wait <= 0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            expected_results.push_back(divide_operands(div_request_t'(s_axis_tdata)));
            send_draw = send_burst ? 0 : $urandom_range(0, 3);
            if ($urandom_range(0, 31) == 0)
                send_burst = !send_burst;
            if (send_draw == 0 && pending_requests.size() != 0)
            begin
                // keep valid high, swap in the next request
                s_axis_tdata <= pending_requests.pop_front();
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
                send_wait <= send_draw;
            end
        end
        else if (!s_axis_tvalid)
        begin
            if (send_wait != 0)
                send_wait <= send_wait - 1;
            else if (pending_requests.size() != 0)
            begin
                s_axis_tdata <= pending_requests.pop_front();
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // Result monitor: check each accepted result, stall tready at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_wait <= 0;
            hold_left <= 0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("result with no request outstanding");
            end
            else
            begin
                div_result_t want;
                want = expected_results.pop_front();
                if (m_axis_tdata[FIELD_W-1:0] !== want.quot)
                    report_mismatch($sformatf("quot %h, expected %h",
                        m_axis_tdata[FIELD_W-1:0], want.quot));
                if (m_axis_tdata[2*FIELD_W-1:FIELD_W] !== want.remain)
                    report_mismatch($sformatf("remain %h, expected %h",
                        m_axis_tdata[2*FIELD_W-1:FIELD_W], want.remain));
                if (m_axis_tuser !== want.div_zero_error)
                    report_mismatch($sformatf("div_zero_error %b, expected %b",
                        m_axis_tuser, want.div_zero_error));
            end
            results_seen++;
            recv_draw = recv_burst ? 0 : $urandom_range(0, 3);
            if ($urandom_range(0, 31) == 0)
                recv_burst = !recv_burst;
            if (results_seen == 200 || results_seen == 500)
            begin
                // long stall so the core backs up and drops s_axis_tready
                hold_left <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else if (recv_draw != 0)
            begin
                m_axis_tready <= 1'b0;
                recv_wait <= recv_draw;
            end
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!m_axis_tready)
        begin
            if (recv_wait != 0)
                recv_wait <= recv_wait - 1;
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: timeout after %0d idle cycles", idle_cycles);
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        logic [FIELD_W-1:0] all_ones;
        logic [FIELD_W-1:0] top_bit;
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] b;
        int                 n;
        all_ones = '1;
        top_bit = {1'b1, {(FIELD_W-1){1'b0}}};

        // zero divisor
        queue_division('0, '0);
        queue_division(all_ones, '0);
        queue_division(64'd5, '0);
        // dividend equal to divisor
        queue_division(64'd1, 64'd1);
        queue_division(all_ones, all_ones);
        queue_division(top_bit, top_bit);
        // dividend below divisor
        queue_division('0, 64'd1);
        queue_division('0, all_ones);
        queue_division(64'd7, 64'd100);
        queue_division(all_ones - 1, all_ones);
        queue_division(64'd1, all_ones);
        // full-length iterations, small divisors and divisors in the upper half
        queue_division(all_ones, 64'd1);
        queue_division(all_ones, 64'd2);
        queue_division(all_ones, 64'd3);
        queue_division(all_ones, top_bit);
        queue_division(all_ones, all_ones - 1);
        queue_division(top_bit + 5, top_bit + 1);
        queue_division(64'hFFFF_0000_0000_0000, 64'd1);
        queue_division(64'h1234_5678_9ABC_DEF0, 64'hFFFF_0000_0000_0000);
        queue_division(64'd100, 64'd7);
        queue_division(top_bit, 64'd3);

        for (n = 0; n < RANDOM_COUNT; n++)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    a = random_operand();
                    b = '0;
                end
                1:
                begin
                    a = random_operand();
                    b = a;
                end
                2:
                begin
                    b = {$urandom(), $urandom()};
                    a = random_operand() % (b == '0 ? 64'd1 : b);
                end
                3:
                begin
                    a = {$urandom(), $urandom()};
                    b = FIELD_W'($urandom_range(1, 255));
                end
                4:
                begin
                    a = {$urandom(), $urandom()};
                    b = {$urandom(), $urandom()};
                end
                default:
                begin
                    a = random_operand();
                    b = random_operand();
                end
            endcase
            queue_division(a, b);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_results.size() != 0)
            report_mismatch("results still outstanding at end");
        if (mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// File: unsigned_divider_core.f
design/udiv_pkg.sv
design/udiv_cell.sv
design/udiv_row.sv
design/unsigned_divider_core.sv
test/tb.sv
